[hw/rtl/i2cra_pkg.sv]
package i2cra_pkg;

  localparam int unsigned DEV_W    = 7;
  localparam int unsigned REG_W    = 16;
  localparam int unsigned DATA_W   = 16;
  localparam int unsigned COUNT_W  = 3;
  localparam int unsigned PHASE_W  = 8;
  localparam int unsigned RDATA_W  = 32;

  // Item classes, one per opcode value.
  typedef enum logic [1:0] {
    KIND_READ   = 2'd0,
    KIND_WRITE  = 2'd1,
    KIND_TICK   = 2'd2,
    KIND_IGNORE = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    STATUS_OK     = 2'd0,
    STATUS_NACK   = 2'd1,
    STATUS_REJECT = 2'd2,
    STATUS_UNUSED = 2'd3
  } status_e;

  // One classified word waiting in the queue.
  typedef struct packed {
    kind_e               kind;
    logic [DEV_W-1:0]    dev_addr;
    logic [REG_W-1:0]    reg_addr;
    logic [DATA_W-1:0]   write_data;
    logic [COUNT_W-1:0]  byte_count;
    logic                sda_in;
  } item_t;

  // Head of the queue as seen by the sequencer.
  typedef struct packed {
    logic  valid;
    item_t item;
  } fq_t;

  // Configuration write as seen by the sequencer.
  typedef struct packed {
    logic               valid;
    logic [PHASE_W-1:0] value;
  } cfg_t;

  typedef struct packed {
    logic               scl_level;
    logic               sda_level;
    logic               busy_res;
    logic               done_res;
    status_e            status;
    logic [RDATA_W-1:0] read_data;
  } res_t;

endpackage

[hw/rtl/i2cra_if.sv]
interface i2cra_in_if;
  logic                              valid;
  logic                              ready;
  logic [1:0]                        opcode;
  logic [i2cra_pkg::DEV_W-1:0]       dev_addr;
  logic [i2cra_pkg::REG_W-1:0]       reg_addr;
  logic [i2cra_pkg::DATA_W-1:0]      write_data;
  logic [i2cra_pkg::COUNT_W-1:0]     byte_count;
  logic                              sda_in;

  modport source (output valid, opcode, dev_addr, reg_addr, write_data, byte_count, sda_in,
                  input ready);
  modport sink (input valid, opcode, dev_addr, reg_addr, write_data, byte_count, sda_in,
                output ready);
endinterface

interface i2cra_out_if;
  logic                              valid;
  logic                              ready;
  logic                              scl_level;
  logic                              sda_level;
  logic                              busy_res;
  logic                              done_res;
  logic [1:0]                        status;
  logic [i2cra_pkg::RDATA_W-1:0]     read_data;

  modport source (output valid, scl_level, sda_level, busy_res, done_res, status, read_data,
                  input ready);
  modport sink (input valid, scl_level, sda_level, busy_res, done_res, status, read_data,
                output ready);
endinterface

interface i2cra_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [i2cra_pkg::PHASE_W-1:0]     phase_length;

  modport source (output valid, phase_length, input ready);
  modport sink (input valid, phase_length, output ready);
endinterface

[hw/rtl/i2c_register_access_master.sv]
// I2C master for 16-bit register access. Each command word (read or write) runs one
// transaction: START, device address, register address high byte first, then either two data
// bytes or a repeated START, the read address and 0..min(MAX_READ_BYTES, 7) bytes, then STOP.
// Tick words advance the line sequencer by one tick, phase_length ticks per line phase, and
// every word in returns exactly one status word out with the resulting SCL/SDA levels, busy,
// done, status and the read accumulator. Throughput is one word per clock when out_o is not
// stalled: a two-entry queue feeds a sequencer that retires one word per cycle into an output
// register, and each word passes through the queue and then the output register. Write
// phase_length only while idle; zero acts as one.
module i2c_register_access_master #(
  parameter int unsigned MAX_READ_BYTES = 4
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  i2cra_in_if.sink     in_i,
  i2cra_cfg_if.sink    cfg_i,
  i2cra_out_if.source  out_o
);

  i2cra_pkg::fq_t  fq;
  i2cra_pkg::cfg_t cfg;
  logic            pop;

  // The register takes a write on any cycle.
  assign cfg_i.ready = 1'b1;
  assign cfg.valid   = cfg_i.valid;
  assign cfg.value   = cfg_i.phase_length;

  // Front: accept and classify words, clamp the read length, hold them in the queue.
  i2cra_front #(
    .MAX_READ_BYTES(MAX_READ_BYTES)
  ) u_front (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_i),
    .pop_i (pop),
    .fq_o  (fq)
  );

  // Back: advance the bus sequencer one word per cycle while the output is not stalled, and register the result.
  i2cra_back u_back (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .fq_i  (fq),
    .pop_o (pop),
    .cfg_i (cfg),
    .out_o (out_o)
  );

endmodule

[hw/rtl/i2cra_front.sv]
module i2cra_front #(
  parameter int unsigned MAX_READ_BYTES = 4
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  i2cra_in_if.sink             in_i,
  input  logic                 pop_i,
  output i2cra_pkg::fq_t       fq_o
);

  localparam int unsigned Depth  = 2;
  localparam int unsigned PtrW   = $clog2(Depth);
  localparam int unsigned CntW   = $clog2(Depth + 1);
  localparam int unsigned CntCap = (MAX_READ_BYTES > ((1 << i2cra_pkg::COUNT_W) - 1)) ?
                                   ((1 << i2cra_pkg::COUNT_W) - 1) : MAX_READ_BYTES;
  localparam logic [i2cra_pkg::COUNT_W-1:0] CountSat = CntCap[i2cra_pkg::COUNT_W-1:0];

  i2cra_pkg::item_t mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  count_q, count_d;
  logic             push;
  i2cra_pkg::item_t item_in;

  // Classify and clamp the read length on the way in.
  always_comb begin
    item_in.kind       = i2cra_pkg::kind_e'(in_i.opcode);
    item_in.dev_addr   = in_i.dev_addr;
    item_in.reg_addr   = in_i.reg_addr;
    item_in.write_data = in_i.write_data;
    item_in.byte_count = (in_i.byte_count > CountSat) ? CountSat : in_i.byte_count;
    item_in.sda_in     = in_i.sda_in;
  end

  assign in_i.ready = (count_q != CntW'(Depth));
  assign push       = in_i.valid && in_i.ready;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (!push && pop_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= item_in;
    end
  end

  assign fq_o.valid = (count_q != '0);
  assign fq_o.item  = mem_q[rd_ptr_q];

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(Depth))
    else $error("queue count beyond depth");

  a_pop_needs_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> count_q != '0)
    else $error("pop from empty queue");

  a_full_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q == CntW'(Depth) |-> !in_i.ready)
    else $error("ready while queue full");

endmodule

[hw/rtl/i2cra_back.sv]
module i2cra_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  i2cra_pkg::fq_t       fq_i,
  output logic                 pop_o,
  input  i2cra_pkg::cfg_t      cfg_i,
  i2cra_out_if.source          out_o
);

  localparam logic [2:0] StIdle   = 3'd0;
  localparam logic [2:0] StStart  = 3'd1;
  localparam logic [2:0] StSend   = 3'd2;
  localparam logic [2:0] StWack   = 3'd3;
  localparam logic [2:0] StRstart = 3'd4;
  localparam logic [2:0] StRead   = 3'd5;
  localparam logic [2:0] StMack   = 3'd6;
  localparam logic [2:0] StStop   = 3'd7;

  localparam int unsigned PW = i2cra_pkg::PHASE_W;
  localparam int unsigned CW = i2cra_pkg::COUNT_W;

  logic [PW-1:0] phase_len_q, phase_len_d;
  logic [2:0]    step_q, step_d;
  logic [1:0]    lp_q, lp_d;
  logic [PW-1:0] pc_q, pc_d;
  logic [2:0]    bc_q, bc_d;
  logic [2:0]    bi_q, bi_d;
  logic [7:0]    sb_q, sb_d;
  logic          wr_q, wr_d;
  logic [i2cra_pkg::DEV_W-1:0]  dev_q, dev_d;
  logic [i2cra_pkg::REG_W-1:0]  reg_q, reg_d;
  logic [i2cra_pkg::DATA_W-1:0] dat_q, dat_d;
  logic [CW-1:0]                 cnt_q, cnt_d;
  logic [i2cra_pkg::RDATA_W-1:0] acc_q, acc_d;
  logic          nack_q, nack_d;

  logic               out_valid_q, out_valid_d;
  i2cra_pkg::res_t    res_q, res_d;
  i2cra_pkg::item_t   it;
  logic               done;
  i2cra_pkg::status_e status;
  logic [PW:0]        len;
  logic [1:0]         last;
  logic [1:0]         lines;

  function automatic logic [7:0] byte_at(input logic [2:0] idx, input logic wr,
                                         input logic [i2cra_pkg::DEV_W-1:0] dev,
                                         input logic [i2cra_pkg::REG_W-1:0] ra,
                                         input logic [i2cra_pkg::DATA_W-1:0] dat);
    logic [7:0] b;
    case (idx)
      3'd0:    b = {dev, 1'b0};
      3'd1:    b = ra[15:8];
      3'd2:    b = ra[7:0];
      3'd3:    b = wr ? dat[15:8] : {dev, 1'b1};
      default: b = dat[7:0];
    endcase
    return b;
  endfunction

  // Returns {scl, sda} for a sequencer state.
  function automatic logic [1:0] line_levels(input logic [2:0] st, input logic [1:0] lp,
                                             input logic [7:0] sb, input logic [2:0] bi,
                                             input logic [CW-1:0] cnt);
    logic hi;
    logic [1:0] v;
    hi = (lp == 2'd1);
    unique case (st) inside
      StStart, StRstart: begin
        v[1] = (lp == 2'd0) ? (st == StStart) : (lp != 2'd3);
        v[0] = (lp < 2'd2);
      end
      StSend:         v = {hi, sb[7]};
      StWack, StRead: v = {hi, 1'b1};
      StMack:         v = {hi, ({1'b0, bi} + 4'd1) >= {1'b0, cnt}};
      StStop: begin
        v[1] = (lp != 2'd0);
        v[0] = (lp == 2'd2);
      end
      default:        v = 2'b11;
    endcase
    return v;
  endfunction

  assign it    = fq_i.item;
  assign pop_o = fq_i.valid && (!out_valid_q || out_o.ready);
  assign len   = (phase_len_q == '0) ? (PW + 1)'(1) : {1'b0, phase_len_q};
  assign last  = (step_q == StStart || step_q == StRstart) ? 2'd3 : 2'd2;

  always_comb begin
    phase_len_d = cfg_i.valid ? cfg_i.value : phase_len_q;
    step_d = step_q;
    lp_d   = lp_q;
    pc_d   = pc_q;
    bc_d   = bc_q;
    bi_d   = bi_q;
    sb_d   = sb_q;
    wr_d   = wr_q;
    dev_d  = dev_q;
    reg_d  = reg_q;
    dat_d  = dat_q;
    cnt_d  = cnt_q;
    acc_d  = acc_q;
    nack_d = nack_q;
    done   = 1'b0;
    status = i2cra_pkg::STATUS_OK;

    if (pop_o) begin
      unique case (it.kind) inside
        i2cra_pkg::KIND_READ, i2cra_pkg::KIND_WRITE: begin
          if (step_q != StIdle) begin
            status = i2cra_pkg::STATUS_REJECT;
          end else begin
            wr_d   = (it.kind == i2cra_pkg::KIND_WRITE);
            dev_d  = it.dev_addr;
            reg_d  = it.reg_addr;
            dat_d  = it.write_data;
            cnt_d  = it.byte_count;
            acc_d  = '0;
            nack_d = 1'b0;
            bc_d   = '0;
            bi_d   = '0;
            sb_d   = '0;
            step_d = StStart;
            lp_d   = '0;
            pc_d   = '0;
          end
        end
        i2cra_pkg::KIND_TICK: begin
          if (step_q != StIdle) begin
            if (({1'b0, pc_q} + (PW + 1)'(1)) < len) begin
              pc_d = pc_q + 1'b1;
            end else begin
              pc_d = '0;
              // Sample SDA at the end of the SCL-high phase.
              if (lp_q == 2'd1) begin
                if (step_q == StWack && it.sda_in) nack_d = 1'b1;
                if (step_q == StRead) sb_d = {sb_q[6:0], it.sda_in};
              end
              if (lp_q < last) begin
                lp_d = lp_q + 1'b1;
              end else begin
                lp_d = '0;
                unique case (step_q)
                  StStart: begin
                    bi_d = 3'd0;
                    sb_d = byte_at(3'd0, wr_q, dev_q, reg_q, dat_q);
                    bc_d = '0;
                    step_d = StSend;
                  end
                  StRstart: begin
                    bi_d = 3'd3;
                    sb_d = byte_at(3'd3, wr_q, dev_q, reg_q, dat_q);
                    bc_d = '0;
                    step_d = StSend;
                  end
                  StSend: begin
                    sb_d = {sb_q[6:0], 1'b0};
                    if (bc_q == 3'd7) begin
                      step_d = StWack;
                    end else begin
                      bc_d = bc_q + 1'b1;
                    end
                  end
                  StWack: begin
                    if (nack_q) begin
                      step_d = StStop;
                    end else if ((wr_q && bi_q < 3'd4) || (!wr_q && bi_q < 3'd2)) begin
                      bi_d = bi_q + 1'b1;
                      sb_d = byte_at(bi_q + 1'b1, wr_q, dev_q, reg_q, dat_q);
                      bc_d = '0;
                      step_d = StSend;
                    end else if (wr_q) begin
                      step_d = StStop;
                    end else if (bi_q == 3'd2) begin
                      step_d = StRstart;
                    end else if (cnt_q == '0) begin
                      step_d = StStop;
                    end else begin
                      bi_d = '0;
                      sb_d = '0;
                      bc_d = '0;
                      step_d = StRead;
                    end
                  end
                  StRead: begin
                    if (bc_q == 3'd7) begin
                      acc_d  = {acc_q[i2cra_pkg::RDATA_W-9:0], sb_q};
                      step_d = StMack;
                    end else begin
                      bc_d = bc_q + 1'b1;
                    end
                  end
                  StMack: begin
                    bi_d = bi_q + 1'b1;
                    if ({1'b0, bi_q} + 4'd1 >= {1'b0, cnt_q}) begin
                      step_d = StStop;
                    end else begin
                      sb_d = '0;
                      bc_d = '0;
                      step_d = StRead;
                    end
                  end
                  StStop: begin
                    step_d = StIdle;
                    done   = 1'b1;
                    status = nack_q ? i2cra_pkg::STATUS_NACK : i2cra_pkg::STATUS_OK;
                  end
                  default: step_d = StIdle;
                endcase
              end
            end
          end
        end
        default: ;
      endcase
    end

    lines = line_levels(step_d, lp_d, sb_d, bi_d, cnt_d);
    res_d.scl_level = lines[1];
    res_d.sda_level = lines[0];
    res_d.busy_res  = (step_d != StIdle);
    res_d.done_res  = done;
    res_d.status    = status;
    res_d.read_data = acc_d;

    out_valid_d = pop_o ? 1'b1 : (out_o.ready ? 1'b0 : out_valid_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_len_q <= PW'(1);
      step_q      <= StIdle;
      lp_q        <= '0;
      pc_q        <= '0;
      bc_q        <= '0;
      bi_q        <= '0;
      sb_q        <= '0;
      wr_q        <= 1'b0;
      dev_q       <= '0;
      reg_q       <= '0;
      dat_q       <= '0;
      cnt_q       <= '0;
      acc_q       <= '0;
      nack_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      phase_len_q <= phase_len_d;
      step_q      <= step_d;
      lp_q        <= lp_d;
      pc_q        <= pc_d;
      bc_q        <= bc_d;
      bi_q        <= bi_d;
      sb_q        <= sb_d;
      wr_q        <= wr_d;
      dev_q       <= dev_d;
      reg_q       <= reg_d;
      dat_q       <= dat_d;
      cnt_q       <= cnt_d;
      acc_q       <= acc_d;
      nack_q      <= nack_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      res_q <= res_d;
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.scl_level = res_q.scl_level;
  assign out_o.sda_level = res_q.sda_level;
  assign out_o.busy_res  = res_q.busy_res;
  assign out_o.done_res  = res_q.done_res;
  assign out_o.status    = res_q.status;
  assign out_o.read_data = res_q.read_data;

  a_done_released: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && res_q.done_res |-> !res_q.busy_res && res_q.scl_level && res_q.sda_level)
    else $error("done word with bus not released");

  a_reject_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && res_q.status == i2cra_pkg::STATUS_REJECT |->
      res_q.busy_res && !res_q.done_res)
    else $error("reject status outside a transaction");

  a_idle_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_q == StIdle |-> pc_q == '0 && lp_q == '0)
    else $error("idle with phase state left over");

  a_busy_tracks_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |=> res_q.busy_res == (step_q != StIdle))
    else $error("busy flag out of step with sequencer");

endmodule
